// ----- sv/rc4_pkg.sv -----
// Shared types, constants and helper functions for the RC4 stream cipher core.
// Depends on nothing; rc4_ctrl, the core and the testbench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  // Permutation memory geometry.
  localparam int unsigned PERM_ADDR_W = 8;
  localparam int unsigned PERM_DATA_W = 8;

  // Key register: four bytes, key byte zero in the low byte.
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned KEY_REG_BYTES = KEY_W / 8;

  // Number of key bytes cycled through by the key schedule (1 to 8).
  localparam int unsigned KEY_BYTES = 4;
  localparam int unsigned KIDX_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,   // waiting for an input transfer
    S_INIT,   // fill pass: S[n] = n
    S_KRD_N,  // schedule: read S[n]
    S_KRD_A,  // schedule: update acc, read S[acc]
    S_KWR_N,  // schedule: write S[n] = S[acc]
    S_KWR_A,  // schedule: write S[acc] = old S[n]
    S_RD_I,   // keystream: i += 1, read S[i]
    S_RD_J,   // keystream: j += S[i], read S[j]
    S_WR_I,   // keystream: write S[i] = S[j], read S[S[i] + S[j]]
    S_WR_J    // keystream: write S[j] = old S[i], emit result
  } state_t;

  // Access request from the sequencer to the permutation memory.
  typedef struct packed {
    logic                   we;
    logic [PERM_ADDR_W-1:0] waddr;
    logic [PERM_DATA_W-1:0] wdata;
    logic                   re;
    logic [PERM_ADDR_W-1:0] raddr;
  } perm_req_t;

  // Key byte for a given position; positions past the register read as zero.
  function automatic logic [7:0] key_byte(input logic [KEY_W-1:0]  key,
                                          input logic [KIDX_W-1:0] idx);
    logic [KEY_W-1:0] shifted;
    shifted = key >> {idx, 3'b000};
    if (32'(idx) >= KEY_REG_BYTES) begin
      key_byte = 8'd0;
    end else begin
      key_byte = shifted[7:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/rc4_perm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Holds the RC4 permutation; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rc4_perm_ram #(
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/rc4_ctrl.sv -----
// Sequencer for the RC4 core: key schedule and keystream steps over the permutation RAM.
// Depends on rc4_pkg; drives the RAM through a perm_req_t request.
`timescale 1ns / 1ps
`default_nettype none

module rc4_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input transfer.
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_data_in,
  input  wire logic                        in_new_message,
  // Key register contents.
  input  wire logic [rc4_pkg::KEY_W-1:0]   key,
  // Result handoff to the output register.
  input  wire logic                        out_free,
  output logic                             res_go,
  output logic [7:0]                       res_byte,
  // Permutation RAM.
  output rc4_pkg::perm_req_t               ram_req,
  input  wire logic [rc4_pkg::PERM_DATA_W-1:0] ram_rdata
);

  rc4_pkg::state_t state_r, state_nxt;

  logic [7:0]                   i_r, i_nxt;
  logic [7:0]                   j_r, j_nxt;
  logic [7:0]                   n_r, n_nxt;
  logic [7:0]                   acc_r, acc_nxt;
  logic [rc4_pkg::KIDX_W-1:0]   kidx_r, kidx_nxt;
  logic                         keyed_r, keyed_nxt;
  logic [7:0]                   data_r, data_nxt;
  logic [7:0]                   si_r, si_nxt;   // S[i] before swap, also old S[n]
  logic [7:0]                   sj_r, sj_nxt;   // S[j] before swap
  logic                         fwd_i_r, fwd_i_nxt;
  logic                         fwd_j_r, fwd_j_nxt;

  logic       in_fire;
  logic       n_last;
  logic [7:0] i_inc;
  logic [7:0] j_sum;
  logic [7:0] t_addr;
  logic [7:0] acc_sum;
  logic [7:0] ks;

  assign in_fire = in_valid && in_ready;
  assign n_last  = (n_r == 8'hFF);
  assign i_inc   = i_r + 8'd1;
  assign j_sum   = j_r + ram_rdata;
  assign t_addr  = si_r + ram_rdata;
  assign acc_sum = acc_r + ram_rdata + rc4_pkg::key_byte(key, kidx_r);

  // Keystream byte: the read of S[t] overlapped the write of S[i] and precedes
  // the write of S[j], so entries just swapped are taken from the swap registers.
  always_comb begin
    if (fwd_j_r) begin
      ks = si_r;
    end else if (fwd_i_r) begin
      ks = sj_r;
    end else begin
      ks = ram_rdata;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rc4_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_new_message || !keyed_r) ? rc4_pkg::S_INIT : rc4_pkg::S_RD_I;
        end
      end
      rc4_pkg::S_INIT:  if (n_last) state_nxt = rc4_pkg::S_KRD_N;
      rc4_pkg::S_KRD_N: state_nxt = rc4_pkg::S_KRD_A;
      rc4_pkg::S_KRD_A: state_nxt = rc4_pkg::S_KWR_N;
      rc4_pkg::S_KWR_N: state_nxt = rc4_pkg::S_KWR_A;
      rc4_pkg::S_KWR_A: state_nxt = n_last ? rc4_pkg::S_RD_I : rc4_pkg::S_KRD_N;
      rc4_pkg::S_RD_I:  state_nxt = rc4_pkg::S_RD_J;
      rc4_pkg::S_RD_J:  state_nxt = rc4_pkg::S_WR_I;
      rc4_pkg::S_WR_I:  state_nxt = rc4_pkg::S_WR_J;
      rc4_pkg::S_WR_J:  if (out_free) state_nxt = rc4_pkg::S_IDLE;
      default:          state_nxt = rc4_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshake, result and RAM requests.
  always_comb begin
    in_ready      = 1'b0;
    res_go        = 1'b0;
    res_byte      = data_r ^ ks;
    ram_req.we    = 1'b0;
    ram_req.waddr = n_r;
    ram_req.wdata = n_r;
    ram_req.re    = 1'b0;
    ram_req.raddr = n_r;
    unique case (state_r)
      rc4_pkg::S_IDLE: in_ready = 1'b1;
      rc4_pkg::S_INIT: ram_req.we = 1'b1;
      rc4_pkg::S_KRD_N: ram_req.re = 1'b1;
      rc4_pkg::S_KRD_A: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = acc_sum;
      end
      rc4_pkg::S_KWR_N: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = ram_rdata;
      end
      rc4_pkg::S_KWR_A: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = acc_r;
        ram_req.wdata = si_r;
      end
      rc4_pkg::S_RD_I: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = i_inc;
      end
      rc4_pkg::S_RD_J: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = j_sum;
      end
      rc4_pkg::S_WR_I: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = i_r;
        ram_req.wdata = ram_rdata;
        ram_req.re    = 1'b1;
        ram_req.raddr = t_addr;
      end
      rc4_pkg::S_WR_J: begin
        // Rewriting the same value while the output stalls is harmless.
        ram_req.we    = 1'b1;
        ram_req.waddr = j_r;
        ram_req.wdata = si_r;
        res_go        = out_free;
      end
      default: ;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    acc_nxt   = acc_r;
    kidx_nxt  = kidx_r;
    keyed_nxt = keyed_r;
    data_nxt  = data_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    fwd_i_nxt = fwd_i_r;
    fwd_j_nxt = fwd_j_r;
    case (state_r)
      rc4_pkg::S_IDLE: begin
        if (in_fire) begin
          data_nxt = in_data_in;
          n_nxt    = 8'd0;
          acc_nxt  = 8'd0;
          kidx_nxt = '0;
        end
      end
      rc4_pkg::S_INIT: n_nxt = n_r + 8'd1;
      rc4_pkg::S_KRD_A: begin
        si_nxt  = ram_rdata;
        acc_nxt = acc_sum;
      end
      rc4_pkg::S_KWR_A: begin
        n_nxt = n_r + 8'd1;
        if (kidx_r == rc4_pkg::KIDX_W'(rc4_pkg::KEY_BYTES - 1)) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = kidx_r + rc4_pkg::KIDX_W'(1);
        end
        if (n_last) begin
          keyed_nxt = 1'b1;
          i_nxt     = 8'd0;
          j_nxt     = 8'd0;
        end
      end
      rc4_pkg::S_RD_I: i_nxt = i_inc;
      rc4_pkg::S_RD_J: begin
        si_nxt = ram_rdata;
        j_nxt  = j_sum;
      end
      rc4_pkg::S_WR_I: begin
        sj_nxt    = ram_rdata;
        fwd_i_nxt = (t_addr == i_r);
        fwd_j_nxt = (t_addr == j_r);
      end
      default: ;
    endcase
  end

  // Control state is reset; the byte registers carry payload only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4_pkg::S_IDLE;
      keyed_r <= 1'b0;
      i_r     <= 8'd0;
      j_r     <= 8'd0;
      n_r     <= 8'd0;
      acc_r   <= 8'd0;
      kidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      keyed_r <= keyed_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      acc_r   <= acc_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    si_r    <= si_nxt;
    sj_r    <= sj_nxt;
    fwd_i_r <= fwd_i_nxt;
    fwd_j_r <= fwd_j_nxt;
  end

  // The schedule completes only from its last swap step.
  a_keyed_from_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(keyed_r) |-> $past(state_r == rc4_pkg::S_KWR_A))
    else $error("keyed set outside the key schedule");

  // Keystream steps never run on an unscheduled permutation.
  a_keyed_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::S_RD_I) |-> keyed_r)
    else $error("keystream step started without a key schedule");

  // An accepted item starts either the schedule or a keystream step.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == rc4_pkg::S_INIT || state_r == rc4_pkg::S_RD_I))
    else $error("accepted item did not start processing");

  // Each result handoff ends its item.
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_go |=> (state_r == rc4_pkg::S_IDLE))
    else $error("result handed off without returning to idle");

endmodule

`default_nettype wire

// ----- sv/rc4_stream_cipher_core.sv -----
// RC4 stream cipher core: key register, output register, sequencer and permutation RAM.
// Depends on rc4_pkg, rc4_perm_ram and rc4_ctrl.
// An input byte runs the four dependent RAM steps of one keystream step (RD_I, RD_J,
//   WR_I, WR_J) before its result is registered; a new byte is taken only from idle.
// A byte that starts a message (or the first byte after reset) first runs the key
//   schedule: a fill pass over all 256 entries, then 256 swaps of KRD_N to KWR_A.
// Reset (synchronous, rst_n low) clears the key register, indices and the keyed flag;
//   the permutation RAM is not cleared, since the first byte always runs the schedule.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input channel.
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_data_in,
  input  wire logic                      in_new_message,
  // Result channel.
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_data_out,
  // Configuration port.
  input  wire logic                      cfg_wr_en,
  input  wire logic [rc4_pkg::KEY_W-1:0] cfg_wr_data
);

  logic [rc4_pkg::KEY_W-1:0]       key_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_data_r, out_data_nxt;
  logic                            out_free;
  logic                            res_go;
  logic [7:0]                      res_byte;
  rc4_pkg::perm_req_t              ram_req;
  logic [rc4_pkg::PERM_DATA_W-1:0] ram_rdata;

  // Key register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      key_r <= cfg_wr_data;
    end
  end

  // Output register: frees up in the same cycle its transfer completes.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_byte;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  // Sequencer.
  rc4_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_in     (in_data_in),
    .in_new_message (in_new_message),
    .key            (key_r),
    .out_free       (out_free),
    .res_go         (res_go),
    .res_byte       (res_byte),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  // Permutation memory.
  rc4_perm_ram #(
    .ADDR_W (rc4_pkg::PERM_ADDR_W),
    .DATA_W (rc4_pkg::PERM_DATA_W)
  ) u_perm_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // A new result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_go |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken output");

  // A held result stays until its transfer completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data_out)))
    else $error("output changed while stalled");

  // Only one item is in flight: no new input while a keystream step runs.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_go |-> !in_ready)
    else $error("input accepted while a result was being produced");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for rc4_stream_cipher_core: RC4 bytes with the key in a register.
// Depends on rc4_pkg and the core; an internal RC4 model predicts every output byte.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_BYTES = 1600;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } cipher_byte_t;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_data_in     = 8'h00;
  logic                      in_new_message = 1'b0;
  logic                      out_valid;
  logic                      out_ready      = 1'b0;
  logic [7:0]                out_data_out;
  logic                      cfg_wr_en      = 1'b0;
  logic [rc4_pkg::KEY_W-1:0] cfg_wr_data    = '0;

  // Model state: permutation, indices, keyed flag and the key register copy.
  logic [7:0]                perm_model [256];
  logic [7:0]                ptr_i      = 8'h00;
  logic [7:0]                ptr_j      = 8'h00;
  bit                        keyed      = 1'b0;
  logic [rc4_pkg::KEY_W-1:0] key_shadow = '0;

  cipher_byte_t byte_pending_q [$];
  logic [7:0]   cipher_expect_q [$];
  cipher_byte_t next_byte;

  int  in_issued      = 0;
  int  in_driven      = 0;
  int  in_accepted    = 0;
  int  out_accepted   = 0;
  int  fail_count     = 0;
  int  cycle_count    = 0;
  int  send_gap       = 0;
  int  recv_stall     = 0;
  int  long_hold_left = 0;
  int  next_long_hold = 200;
  bit  no_idle        = 1'b0;

  rc4_stream_cipher_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_in     (in_data_in),
    .in_new_message (in_new_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Random idle length: mostly none or short, now and then long.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // One RC4 step for an accepted byte, rerunning the key schedule when the
  // byte starts a message or nothing has been keyed since reset.
  task automatic rc4_encrypt_byte(input logic [7:0] din, input logic start,
                                  output logic [7:0] dout);
    int         n;
    int         kpos;
    logic [7:0] acc;
    logic [7:0] kb;
    logic [7:0] t;
    logic [7:0] sum;
    if (start || !keyed) begin
      for (n = 0; n < 256; n++) perm_model[n] = 8'(n);
      acc = 8'h00;
      for (n = 0; n < 256; n++) begin
        kpos = n % rc4_pkg::KEY_BYTES;
        kb   = (kpos >= rc4_pkg::KEY_REG_BYTES) ? 8'h00 : key_shadow[8*kpos +: 8];
        acc  = acc + perm_model[n] + kb;
        t              = perm_model[n];
        perm_model[n]  = perm_model[acc];
        perm_model[acc] = t;
      end
      ptr_i = 8'h00;
      ptr_j = 8'h00;
      keyed = 1'b1;
    end
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + perm_model[ptr_i];
    t                 = perm_model[ptr_i];
    perm_model[ptr_i] = perm_model[ptr_j];
    perm_model[ptr_j] = t;
    sum  = perm_model[ptr_i] + perm_model[ptr_j];
    dout = din ^ perm_model[sum];
  endtask

  // Rising edge: track key writes, predict accepted bytes, check output transfers.
  always @(posedge clk) begin
    logic [7:0] predicted;
    logic [7:0] want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("rc4_stream_cipher_core regression: fail");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) key_shadow = cfg_wr_data;
      if (in_valid && in_ready) begin
        rc4_encrypt_byte(in_data_in, in_new_message, predicted);
        cipher_expect_q.push_back(predicted);
        in_accepted++;
      end
      if (out_valid && out_ready) begin
        out_accepted++;
        if (cipher_expect_q.size() == 0) begin
          $display("%0t: unexpected data_out transfer, expected none, actual %02h",
                   $time, out_data_out);
          fail_count++;
        end else begin
          want = cipher_expect_q.pop_front();
          if (out_data_out !== want) begin
            $display("%0t: data_out mismatch, expected %02h, actual %02h",
                     $time, want, out_data_out);
            fail_count++;
          end
        end
      end
    end
  end

  // Input driver: holds a byte until its transfer, then idles or sends the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_accepted != in_driven) begin
      // Still waiting for the transfer; payload stays put.
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (byte_pending_q.size() > 0) begin
      next_byte = byte_pending_q.pop_front();
      in_valid       <= 1'b1;
      in_data_in     <= next_byte.data;
      in_new_message <= next_byte.start;
      in_driven++;
      if (!no_idle) send_gap = idle_span();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output side: random stalls plus a few long hold-offs that back the core up.
  always @(negedge clk) begin
    if (long_hold_left > 0) begin
      out_ready <= 1'b0;
      long_hold_left--;
    end else if (out_accepted >= next_long_hold) begin
      out_ready <= 1'b0;
      long_hold_left = LONG_HOLD;
      next_long_hold += 700;
    end else if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall--;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle) recv_stall = idle_span();
    end
  end

  task automatic queue_byte(input logic [7:0] data, input logic start);
    cipher_byte_t b;
    b.data  = data;
    b.start = start;
    byte_pending_q.push_back(b);
    in_issued++;
  endtask

  // Waits until every byte has been taken and every output byte has come back.
  task automatic wait_drained();
    while (in_accepted != in_issued || cipher_expect_q.size() != 0) @(negedge clk);
  endtask

  // Key writes happen only with the core drained; cfg_wr_en drops before the task returns.
  task automatic write_key(input logic [rc4_pkg::KEY_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus: reset, directed bytes, then random messages under random keys.
  initial begin
    int                        directed_total;
    int                        msgs;
    int                        len;
    int                        m;
    int                        b;
    int                        r;
    logic                      first_flag;
    logic [rc4_pkg::KEY_W-1:0] key_val;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First byte after reset runs the schedule without the start flag.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);

    // Key change mid-message: the running permutation is kept until a restart.
    write_key(32'hFFFF_FFFF);
    no_idle = 1'b1;
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h3C, 1'b1);
    queue_byte(8'hC3, 1'b1);

    write_key(32'h0000_0000);
    no_idle = 1'b0;
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);

    write_key(32'h0123_4567);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'hFE, 1'b0);
    directed_total = in_issued;

    // Random phases: a few messages each, mostly keyed fresh, with the
    // occasional continuation across a key change and stray restarts.
    while (in_issued < directed_total + RANDOM_BYTES) begin
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 9);
        key_val = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        write_key(key_val);
      end else begin
        wait_drained();
      end
      no_idle = ($urandom_range(0, 3) == 0);
      msgs = $urandom_range(1, 4);
      for (m = 0; m < msgs; m++) begin
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        first_flag = (m == 0 && $urandom_range(0, 4) == 0) ? 1'b0 : 1'b1;
        for (b = 0; b < len; b++) begin
          queue_byte(8'($urandom_range(0, 255)),
                     (b == 0) ? first_flag : ($urandom_range(0, 49) == 0));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && cipher_expect_q.size() == 0) begin
      $display("rc4_stream_cipher_core regression: pass");
    end else begin
      $display("rc4_stream_cipher_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- rc4_stream_cipher_core.f -----
sv/rc4_pkg.sv
sv/rc4_perm_ram.sv
sv/rc4_ctrl.sv
sv/rc4_stream_cipher_core.sv
test/tb_top.sv
